/* hdl/qlm_pkg.sv */
package qlm_pkg;

  // Number formats of the ports.
  localparam int FRAC_BITS  = 14;
  localparam int COMP_WIDTH = 16;
  localparam int OUT_WIDTH  = COMP_WIDTH + 2;

  // Internal angle and root format: Q.30.
  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 31;

  // Square root: one result bit per stage.
  localparam int ROOT_W   = ANG_BITS + 1;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_WIDTH = 2 * SQ_STEPS;
  localparam int REM_W    = ROOT_W + 2;

  // CORDIC datapath width, with headroom for the gain and the sign.
  localparam int CW_W = ANG_BITS + 4;

  // Divider: quotient bits produced after the overflow check decides.
  localparam int QUO_W  = OUT_WIDTH + 1;
  localparam int PROD_W = CW_W + COMP_WIDTH;
  localparam int NUM_W  = PROD_W + 1;

  // Three vector components travel together.
  typedef logic [2:0][COMP_WIDTH-1:0] comp3_t;

  // Arctangent of 2^-i in Q.30 radians.
  function automatic logic [CW_W-1:0] atan_q30(input int i);
    logic [CW_W-1:0] v;
    case (i)
      0:       v = CW_W'(64'd843314857);
      1:       v = CW_W'(64'd497837829);
      2:       v = CW_W'(64'd263043837);
      3:       v = CW_W'(64'd133525159);
      4:       v = CW_W'(64'd67021687);
      5:       v = CW_W'(64'd33543516);
      6:       v = CW_W'(64'd16775851);
      7:       v = CW_W'(64'd8388437);
      8:       v = CW_W'(64'd4194283);
      9:       v = CW_W'(64'd2097149);
      default: v = CW_W'(64'd1 << (ANG_BITS - i));
    endcase
    return v;
  endfunction

endpackage

/* hdl/qlm_sqrt.sv */
module qlm_sqrt (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [qlm_pkg::SQ_WIDTH-1:0]           in_rad,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0]  in_w,
  input  qlm_pkg::comp3_t                        in_c,
  output logic                                   out_valid,
  output logic [qlm_pkg::ROOT_W-1:0]             out_root,
  output logic signed [qlm_pkg::COMP_WIDTH-1:0]  out_w,
  output qlm_pkg::comp3_t                        out_c
);
  import qlm_pkg::*;

  logic                         vld_r  [SQ_STEPS];
  logic [SQ_WIDTH-1:0]          rad_r  [SQ_STEPS];
  logic [REM_W-1:0]             rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]            root_r [SQ_STEPS];
  logic signed [COMP_WIDTH-1:0] w_r    [SQ_STEPS];
  comp3_t                       c_r    [SQ_STEPS];

  // One restoring square-root step per stage, two radicand bits at a time.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    logic                         src_vld;
    logic [SQ_WIDTH-1:0]          src_rad;
    logic [REM_W-1:0]             src_rem;
    logic [ROOT_W-1:0]            src_root;
    logic signed [COMP_WIDTH-1:0] src_w;
    comp3_t                       src_c;
    logic [REM_W-1:0]             r2;
    logic [REM_W-1:0]             trial;
    logic [REM_W-1:0]             rem_nxt;
    logic [ROOT_W-1:0]            root_nxt;

    if (k == 0) begin : g_head
      assign src_vld  = in_valid;
      assign src_rad  = in_rad;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_w    = in_w;
      assign src_c    = in_c;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_w    = w_r[k-1];
      assign src_c    = c_r[k-1];
    end

    // Bring down the next bit pair and try the trial divisor.
    always_comb begin
      r2    = {src_rem[REM_W-3:0], src_rad[SQ_WIDTH-1-2*k -: 2]};
      trial = {src_root, 2'b01};
      if (r2 >= trial) begin
        rem_nxt  = r2 - trial;
        root_nxt = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = r2;
        root_nxt = {src_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= src_rad;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        w_r[k]    <= src_w;
        c_r[k]    <= src_c;
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1];
  assign out_w     = w_r[SQ_STEPS-1];
  assign out_c     = c_r[SQ_STEPS-1];

endmodule

/* hdl/qlm_cordic.sv */
module qlm_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0] in_w,
  input  logic [qlm_pkg::ROOT_W-1:0]            in_root,
  input  qlm_pkg::comp3_t                       in_c,
  output logic                                  out_valid,
  output logic signed [qlm_pkg::CW_W-1:0]       out_z,
  output logic [qlm_pkg::ROOT_W-1:0]            out_root,
  output logic                                  out_zero,
  output qlm_pkg::comp3_t                       out_c
);
  import qlm_pkg::*;

  logic signed [CW_W-1:0] xw;
  logic signed [CW_W-1:0] yr;
  logic signed [CW_W-1:0] px_nxt, py_nxt, pz_nxt;

  logic                   pv_r;
  logic signed [CW_W-1:0] px_r, py_r, pz_r;
  logic [ROOT_W-1:0]      proot_r;
  logic                   pzero_r;
  comp3_t                 pc_r;

  // Preparation: fold the left half plane into the right one.
  always_comb begin
    xw = $signed({{(CW_W-COMP_WIDTH){in_w[COMP_WIDTH-1]}}, in_w}) <<< (ANG_BITS - FRAC_BITS);
    yr = $signed({{(CW_W-ROOT_W){1'b0}}, in_root});
    if (xw < 0) begin
      px_nxt = yr;
      py_nxt = -xw;
      pz_nxt = $signed(atan_q30(0) << 1);
    end else begin
      px_nxt = xw;
      py_nxt = yr;
      pz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      proot_r <= in_root;
      pzero_r <= (in_root == '0);
      pc_r    <= in_c;
    end
  end

  logic                   vld_r  [CORDIC_STEPS];
  logic signed [CW_W-1:0] x_r    [CORDIC_STEPS];
  logic signed [CW_W-1:0] y_r    [CORDIC_STEPS];
  logic signed [CW_W-1:0] z_r    [CORDIC_STEPS];
  logic [ROOT_W-1:0]      root_r [CORDIC_STEPS];
  logic                   zero_r [CORDIC_STEPS];
  comp3_t                 c_r    [CORDIC_STEPS];

  // One vectoring rotation per stage with a fixed shift.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    logic                   src_vld;
    logic signed [CW_W-1:0] src_x, src_y, src_z;
    logic [ROOT_W-1:0]      src_root;
    logic                   src_zero;
    comp3_t                 src_c;
    logic signed [CW_W-1:0] xs, ys;
    logic signed [CW_W-1:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_head
      assign src_vld  = pv_r;
      assign src_x    = px_r;
      assign src_y    = py_r;
      assign src_z    = pz_r;
      assign src_root = proot_r;
      assign src_zero = pzero_r;
      assign src_c    = pc_r;
    end else begin : g_next
      assign src_vld  = vld_r[i-1];
      assign src_x    = x_r[i-1];
      assign src_y    = y_r[i-1];
      assign src_z    = z_r[i-1];
      assign src_root = root_r[i-1];
      assign src_zero = zero_r[i-1];
      assign src_c    = c_r[i-1];
    end

    always_comb begin
      xs = src_x >>> i;
      ys = src_y >>> i;
      if (src_y > 0) begin
        x_nxt = src_x + ys;
        y_nxt = src_y - xs;
        z_nxt = src_z + $signed(atan_q30(i));
      end else begin
        x_nxt = src_x - ys;
        y_nxt = src_y + xs;
        z_nxt = src_z - $signed(atan_q30(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        root_r[i] <= src_root;
        zero_r[i] <= src_zero;
        c_r[i]    <= src_c;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign out_z     = z_r[CORDIC_STEPS-1];
  assign out_root  = root_r[CORDIC_STEPS-1];
  assign out_zero  = zero_r[CORDIC_STEPS-1];
  assign out_c     = c_r[CORDIC_STEPS-1];

endmodule

/* hdl/qlm_div.sv */
module qlm_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [qlm_pkg::CW_W-1:0]       in_z,
  input  logic [qlm_pkg::ROOT_W-1:0]            in_root,
  input  logic                                  in_zero,
  input  qlm_pkg::comp3_t                       in_c,
  output logic                                  out_valid,
  output logic [2:0][qlm_pkg::QUO_W-1:0]        out_quo,
  output logic [2:0]                            out_ovf,
  output logic [2:0]                            out_neg,
  output logic                                  out_zero
);
  import qlm_pkg::*;

  // Stage A: doubled angle times component magnitude.
  logic [CW_W-1:0]              t2;
  logic [2:0][COMP_WIDTH-1:0]   cm;
  logic [2:0][PROD_W-1:0]       prod_nxt;

  logic                         a_v_r;
  logic [2:0][PROD_W-1:0]       a_prod_r;
  logic [ROOT_W-1:0]            a_s_r;
  logic                         a_zero_r;
  logic [2:0]                   a_neg_r;

  always_comb begin
    t2 = in_z[CW_W-1] ? '0 : {in_z[CW_W-2:0], 1'b0};
    for (int l = 0; l < 3; l++) begin
      cm[l]       = in_c[l][COMP_WIDTH-1] ? (~in_c[l] + 1'b1) : in_c[l];
      prod_nxt[l] = {{COMP_WIDTH{1'b0}}, t2} * {{CW_W{1'b0}}, cm[l]};
    end
  end

  // Stage B: add half the divisor for rounding.
  logic                         b_v_r;
  logic [2:0][NUM_W-1:0]        b_num_r;
  logic [ROOT_W-1:0]            b_s_r;
  logic                         b_zero_r;
  logic [2:0]                   b_neg_r;
  logic [2:0][NUM_W-1:0]        num_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_nxt[l] = {1'b0, a_prod_r[l]} + {{(NUM_W-ROOT_W+1){1'b0}}, a_s_r[ROOT_W-1:1]};
    end
  end

  // Stage C: a high part not below the divisor means the quotient overflows.
  logic                         c_v_r;
  logic [2:0][ROOT_W-1:0]       c_rem_r;
  logic [2:0][QUO_W-1:0]        c_lo_r;
  logic [2:0]                   c_ovf_r;
  logic [ROOT_W-1:0]            c_s_r;
  logic                         c_zero_r;
  logic [2:0]                   c_neg_r;
  logic [2:0][NUM_W-QUO_W-1:0]  hi;
  logic [2:0]                   ovf_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      hi[l]      = b_num_r[l][NUM_W-1:QUO_W];
      ovf_nxt[l] = hi[l] >= {{(NUM_W-QUO_W-ROOT_W){1'b0}}, b_s_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= prod_nxt;
      a_s_r    <= in_root;
      a_zero_r <= in_zero;
      for (int l = 0; l < 3; l++) begin
        a_neg_r[l] <= in_c[l][COMP_WIDTH-1];
      end
      b_num_r  <= num_nxt;
      b_s_r    <= a_s_r;
      b_zero_r <= a_zero_r;
      b_neg_r  <= a_neg_r;
      for (int l = 0; l < 3; l++) begin
        c_rem_r[l] <= hi[l][ROOT_W-1:0];
        c_lo_r[l]  <= b_num_r[l][QUO_W-1:0];
      end
      c_ovf_r  <= ovf_nxt;
      c_s_r    <= b_s_r;
      c_zero_r <= b_zero_r;
      c_neg_r  <= b_neg_r;
    end
  end

  // Restoring division, one quotient bit per stage in each of three lanes.
  logic                   vld_r  [QUO_W];
  logic [2:0][ROOT_W-1:0] rem_r  [QUO_W];
  logic [2:0][QUO_W-1:0]  lo_r   [QUO_W];
  logic [2:0][QUO_W-1:0]  quo_r  [QUO_W];
  logic [2:0]             ovf_r  [QUO_W];
  logic [ROOT_W-1:0]      s_r    [QUO_W];
  logic                   zero_r [QUO_W];
  logic [2:0]             neg_r  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_st
    logic                   src_vld;
    logic [2:0][ROOT_W-1:0] src_rem;
    logic [2:0][QUO_W-1:0]  src_lo;
    logic [2:0][QUO_W-1:0]  src_quo;
    logic [2:0]             src_ovf;
    logic [ROOT_W-1:0]      src_s;
    logic                   src_zero;
    logic [2:0]             src_neg;
    logic [2:0][ROOT_W:0]   r2;
    logic [2:0]             ge;
    logic [2:0][ROOT_W-1:0] rem_nxt;
    logic [2:0][QUO_W-1:0]  quo_nxt;

    if (j == 0) begin : g_head
      assign src_vld  = c_v_r;
      assign src_rem  = c_rem_r;
      assign src_lo   = c_lo_r;
      assign src_quo  = '0;
      assign src_ovf  = c_ovf_r;
      assign src_s    = c_s_r;
      assign src_zero = c_zero_r;
      assign src_neg  = c_neg_r;
    end else begin : g_next
      assign src_vld  = vld_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_lo   = lo_r[j-1];
      assign src_quo  = quo_r[j-1];
      assign src_ovf  = ovf_r[j-1];
      assign src_s    = s_r[j-1];
      assign src_zero = zero_r[j-1];
      assign src_neg  = neg_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        r2[l]      = {src_rem[l], src_lo[l][QUO_W-1-j]};
        ge[l]      = r2[l] >= {1'b0, src_s};
        rem_nxt[l] = ge[l] ? ROOT_W'(r2[l] - {1'b0, src_s}) : r2[l][ROOT_W-1:0];
        quo_nxt[l] = {src_quo[l][QUO_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        lo_r[j]   <= src_lo;
        quo_r[j]  <= quo_nxt;
        ovf_r[j]  <= src_ovf;
        s_r[j]    <= src_s;
        zero_r[j] <= src_zero;
        neg_r[j]  <= src_neg;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_ovf   = ovf_r[QUO_W-1];
  assign out_neg   = neg_r[QUO_W-1];
  assign out_zero  = zero_r[QUO_W-1];

endmodule

/* hdl/quaternion_log_map.sv */
// Pipeline from an accepted request to its result: 1 input stage, 31 square-root stages,
// 32 CORDIC stages, 22 divider stages and 1 output register.
// Throughput: one request per cycle; the whole pipeline advances together and holds while
// a finished result is stalled at the output.
// Reset: synchronous and active low; it clears every valid bit, payload registers keep data.
module quaternion_log_map (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_w,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_x,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_y,
  input  logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_x,
  output logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_y,
  output logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_z,
  output logic                                  out_saturated
);
  import qlm_pkg::*;

  localparam logic signed [COMP_WIDTH-1:0] ONE = COMP_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
  localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'd1 << (OUT_WIDTH - 1));

  logic en;

  // Every stage moves unless the result register holds a stalled request.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input stage: clamp the scalar part and form (1 - w^2) scaled for the root.
  logic signed [COMP_WIDTH-1:0] wc;
  logic [FRAC_BITS:0]           wmag;
  logic [2*FRAC_BITS+1:0]       wsq;
  logic [2*FRAC_BITS+1:0]       diff;
  logic [SQ_WIDTH-1:0]          rad_nxt;

  logic                         s0_v_r;
  logic [SQ_WIDTH-1:0]          s0_rad_r;
  logic signed [COMP_WIDTH-1:0] s0_w_r;
  comp3_t                       s0_c_r;

  always_comb begin
    if (in_q_w > ONE) begin
      wc = ONE;
    end else if (in_q_w < -ONE) begin
      wc = -ONE;
    end else begin
      wc = in_q_w;
    end
    wmag    = wc[COMP_WIDTH-1] ? FRAC_BITS'(-wc) + (FRAC_BITS+1)'(0) : wc[FRAC_BITS:0];
    if (wc == -ONE) begin
      wmag = ONE[FRAC_BITS:0];
    end
    wsq     = {{(FRAC_BITS+1){1'b0}}, wmag} * {{(FRAC_BITS+1){1'b0}}, wmag};
    diff    = ((2*FRAC_BITS+2)'(1) << (2*FRAC_BITS)) - wsq;
    rad_nxt = SQ_WIDTH'({{(SQ_WIDTH){1'b0}}, diff} << (2*ANG_BITS - 2*FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rad_r <= rad_nxt;
      s0_w_r   <= wc;
      s0_c_r   <= {in_q_z, in_q_y, in_q_x};
    end
  end

  // Square root of (1 - w^2) in Q.30.
  logic                         sq_v;
  logic [ROOT_W-1:0]            sq_root;
  logic signed [COMP_WIDTH-1:0] sq_w;
  comp3_t                       sq_c;

  qlm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_rad    (s0_rad_r),
    .in_w      (s0_w_r),
    .in_c      (s0_c_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_w     (sq_w),
    .out_c     (sq_c)
  );

  // Half angle atan2(s, w) in Q.30 radians.
  logic                   co_v;
  logic signed [CW_W-1:0] co_z;
  logic [ROOT_W-1:0]      co_root;
  logic                   co_zero;
  comp3_t                 co_c;

  qlm_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_w      (sq_w),
    .in_root   (sq_root),
    .in_c      (sq_c),
    .out_valid (co_v),
    .out_z     (co_z),
    .out_root  (co_root),
    .out_zero  (co_zero),
    .out_c     (co_c)
  );

  // Component magnitudes 2a*|c|/s, rounded.
  logic                        dv_v;
  logic [2:0][QUO_W-1:0]       dv_quo;
  logic [2:0]                  dv_ovf;
  logic [2:0]                  dv_neg;
  logic                        dv_zero;

  qlm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (co_v),
    .in_z      (co_z),
    .in_root   (co_root),
    .in_zero   (co_zero),
    .in_c      (co_c),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf),
    .out_neg   (dv_neg),
    .out_zero  (dv_zero)
  );

  // Output stage: clip to the output range, apply the sign.
  logic [2:0][OUT_WIDTH-1:0] rot_nxt;
  logic [2:0][OUT_WIDTH-1:0] mag;
  logic [2:0]                clip;
  logic                      sat_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_neg[l]) begin
        clip[l] = dv_ovf[l] || (dv_quo[l] > LIM_NEG);
        mag[l]  = clip[l] ? LIM_NEG[OUT_WIDTH-1:0] : dv_quo[l][OUT_WIDTH-1:0];
        rot_nxt[l] = -mag[l];
      end else begin
        clip[l] = dv_ovf[l] || (dv_quo[l] > LIM_POS);
        mag[l]  = clip[l] ? LIM_POS[OUT_WIDTH-1:0] : dv_quo[l][OUT_WIDTH-1:0];
        rot_nxt[l] = mag[l];
      end
    end
    sat_nxt = |clip;
    // A zero sine gives the zero vector.
    if (dv_zero) begin
      rot_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot_x     <= rot_nxt[0];
      out_rot_y     <= rot_nxt[1];
      out_rot_z     <= rot_nxt[2];
      out_saturated <= sat_nxt;
    end
  end

endmodule

/* hdl/qlm_checker.sv */
module qlm_props (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_w,
  input logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_x,
  input logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_y,
  input logic signed [qlm_pkg::COMP_WIDTH-1:0] in_q_z,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_x,
  input logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_y,
  input logic signed [qlm_pkg::OUT_WIDTH-1:0]  out_rot_z,
  input logic                                  out_saturated
);
  import qlm_pkg::*;

  localparam logic signed [OUT_WIDTH-1:0] RMAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] RMIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  // The input side only waits while a finished result is held.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held result");

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z) && $stable(out_saturated))
    else $error("stalled result changed");

  // A clipped result has at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_rot_x == RMAX || out_rot_x == RMIN
      || out_rot_y == RMAX || out_rot_y == RMIN || out_rot_z == RMAX || out_rot_z == RMIN)
    else $error("saturation flag without a clipped component");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_log_map qlm_props u_qlm_props (.*);
